// ===== hdl/epa_pkg.sv =====
// Shared types, constants and lookup functions of the event plane angle unit.
package epa_pkg;

  localparam int unsigned CH_W     = 6;
  localparam int unsigned CHG_W    = 12;
  localparam int unsigned ANG_W    = 17;
  localparam int unsigned CSUM_W   = 18;
  localparam int unsigned Q_W      = 36;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned ACC_W    = 18;
  localparam int unsigned ROT_W    = 40;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned ATAN_W   = 14;

  localparam logic [CH_W-1:0]   NUM_CH    = 6'd48;
  localparam logic [CSUM_W-1:0] CSUM_MAX  = 18'h3FFFF;
  localparam logic signed [ACC_W-1:0] ANG_HALF_PI = 18'sd16384;
  localparam logic signed [ACC_W-1:0] ANG_MAX     = 18'sd32768;
  localparam logic signed [ACC_W-1:0] ANG_MIN     = -18'sd32768;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos2;
    logic signed [COEF_W-1:0] sin2;
  } coef_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  // cos(2phi), sin(2phi) in Q1.14 for a channel inside the valid range
  function automatic coef_t seg_coef(logic [CH_W-1:0] ch);
    logic [1:0] m8;
    logic [2:0] m16;
    coef_t      c;
    m8  = 2'd0;
    m16 = 3'd0;
    c   = '0;
    case (ch[2:0])
      3'd0: m8 = 2'd1;
      3'd1: m8 = 2'd0;
      3'd2: m8 = 2'd3;
      3'd3: m8 = 2'd2;
      3'd4: m8 = 2'd2;
      3'd5: m8 = 2'd3;
      3'd6: m8 = 2'd0;
      default: m8 = 2'd1;
    endcase
    case (ch[3:0])
      4'd0:  m16 = 3'd3;
      4'd1:  m16 = 3'd1;
      4'd2:  m16 = 3'd7;
      4'd3:  m16 = 3'd5;
      4'd4:  m16 = 3'd5;
      4'd5:  m16 = 3'd7;
      4'd6:  m16 = 3'd1;
      4'd7:  m16 = 3'd3;
      4'd8:  m16 = 3'd2;
      4'd9:  m16 = 3'd0;
      4'd10: m16 = 3'd6;
      4'd11: m16 = 3'd4;
      4'd12: m16 = 3'd4;
      4'd13: m16 = 3'd6;
      4'd14: m16 = 3'd0;
      default: m16 = 3'd2;
    endcase
    if (ch < 6'd32) begin
      case (m8)
        2'd0: c = '{cos2: 16'sd11585,  sin2: 16'sd11585};
        2'd1: c = '{cos2: -16'sd11585, sin2: 16'sd11585};
        2'd2: c = '{cos2: -16'sd11585, sin2: -16'sd11585};
        default: c = '{cos2: 16'sd11585, sin2: -16'sd11585};
      endcase
    end else begin
      case (m16)
        3'd0: c = '{cos2: 16'sd15137,  sin2: 16'sd6270};
        3'd1: c = '{cos2: 16'sd6270,   sin2: 16'sd15137};
        3'd2: c = '{cos2: -16'sd6270,  sin2: 16'sd15137};
        3'd3: c = '{cos2: -16'sd15137, sin2: 16'sd6270};
        3'd4: c = '{cos2: -16'sd15137, sin2: -16'sd6270};
        3'd5: c = '{cos2: -16'sd6270,  sin2: -16'sd15137};
        3'd6: c = '{cos2: 16'sd6270,   sin2: -16'sd15137};
        default: c = '{cos2: 16'sd15137, sin2: -16'sd6270};
      endcase
    end
    return c;
  endfunction

  // atan(2^-i) in units of pi/32768
  function automatic logic [ATAN_W-1:0] atan_unit(logic [4:0] idx);
    logic [ATAN_W-1:0] a;
    case (idx)
      5'd0:  a = 14'd8192;
      5'd1:  a = 14'd4836;
      5'd2:  a = 14'd2555;
      5'd3:  a = 14'd1297;
      5'd4:  a = 14'd651;
      5'd5:  a = 14'd326;
      5'd6:  a = 14'd163;
      5'd7:  a = 14'd81;
      5'd8:  a = 14'd41;
      5'd9:  a = 14'd20;
      5'd10: a = 14'd10;
      5'd11: a = 14'd5;
      5'd12: a = 14'd3;
      5'd13: a = 14'd1;
      5'd14: a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/epa_accum.sv =====
// Saturating Q-vector and charge accumulators of one bunch crossing.
module epa_accum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  epa_pkg::acc_ctrl_t                 ctrl_i,
  input  logic [epa_pkg::CHG_W-1:0]          q_i,
  input  epa_pkg::coef_t                     coef_i,
  output logic signed [epa_pkg::Q_W-1:0]     qx_o,
  output logic signed [epa_pkg::Q_W-1:0]     qy_o,
  output logic [epa_pkg::CSUM_W-1:0]         csum_o
);
  import epa_pkg::*;

  localparam int unsigned P_W = CHG_W + 1 + COEF_W;

  logic signed [Q_W-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic [CSUM_W-1:0]      csum_q, csum_d;
  logic signed [P_W-1:0]  px, py;
  logic signed [Q_W:0]    sx, sy;
  logic [CSUM_W:0]        sc;

  function automatic logic signed [Q_W-1:0] sat_q(logic signed [Q_W:0] v);
    logic signed [Q_W-1:0] r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  assign px = $signed({1'b0, q_i}) * coef_i.cos2;
  assign py = $signed({1'b0, q_i}) * coef_i.sin2;
  assign sx = (Q_W+1)'(qx_q) + (Q_W+1)'(px);
  assign sy = (Q_W+1)'(qy_q) + (Q_W+1)'(py);
  assign sc = {1'b0, csum_q} + (CSUM_W+1)'(q_i);

  always_comb begin
    qx_d   = qx_q;
    qy_d   = qy_q;
    csum_d = csum_q;
    if (ctrl_i.clear) begin
      qx_d   = '0;
      qy_d   = '0;
      csum_d = '0;
    end else if (ctrl_i.add) begin
      qx_d   = sat_q(sx);
      qy_d   = sat_q(sy);
      csum_d = sc[CSUM_W] ? CSUM_MAX : sc[CSUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q   <= '0;
      qy_q   <= '0;
      csum_q <= '0;
    end else begin
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      csum_q <= csum_d;
    end
  end

  assign qx_o   = qx_q;
  assign qy_o   = qy_q;
  assign csum_o = csum_q;

endmodule

// ===== hdl/epa_cordic.sv =====
// Iterative vectoring CORDIC: one rotation step per cycle on a shared add/shift unit.
module epa_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [epa_pkg::Q_W-1:0]      x_i,
  input  logic signed [epa_pkg::Q_W-1:0]      y_i,
  output logic                                done_o,
  output logic signed [epa_pkg::ANG_W-1:0]    angle_o
);
  import epa_pkg::*;

  localparam int unsigned N      = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam int unsigned STEP_W = (N > 1) ? $clog2(N) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N - 1);

  logic signed [ROT_W-1:0] x_q, x_d, y_q, y_d, x0, y0, dx, dy;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc0, acc_fin;
  logic signed [ACC_W-1:0] atan_s;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic signed [ANG_W-1:0] angle_q, angle_d;

  // quadrant pre-rotation by +-pi/2 for a vector in the left half plane
  always_comb begin
    x0   = ROT_W'(x_i);
    y0   = ROT_W'(y_i);
    acc0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0   = ROT_W'(y_i);
        y0   = -ROT_W'(x_i);
        acc0 = ANG_HALF_PI;
      end else begin
        x0   = -ROT_W'(y_i);
        y0   = ROT_W'(x_i);
        acc0 = -ANG_HALF_PI;
      end
    end
  end

  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_s = $signed({{(ACC_W-ATAN_W){1'b0}}, atan_unit(5'(step_q))});

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    angle_d = angle_q;
    acc_fin = acc_q;
    if (start_i) begin
      x_d    = x0;
      y_d    = y0;
      acc_d  = acc0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        acc_d = acc_q + atan_s;
      end else begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        acc_d = acc_q - atan_s;
      end
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        acc_fin = acc_d;
        if (acc_d > ANG_MAX) acc_fin = ANG_MAX;
        if (acc_d < ANG_MIN) acc_fin = ANG_MIN;
        angle_d = acc_fin[ANG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    angle_q <= angle_d;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

// ===== hdl/event_plane_angle_unit.sv =====
// Top level of the event plane angle unit: hit sequencer, accumulators, CORDIC, result register.
//
// Input channel: one channel hit per word (channel_i, charge_i, last_i) on
// in_valid_i / in_ready_o. Only the low CHARGE_BITS bits of charge_i count;
// channels 48..63 add nothing but their last flag still ends the crossing.
// A hit is taken in its accept cycle and then passes an accumulate state in which
// both charge*coefficient products are added into the saturating Q sums.
// in_ready_o is low during that state.
// A hit with last_i set then passes a finish state and runs the CORDIC, one
// rotation per cycle for min(CORDIC_STEPS, 24) steps; the result word is then
// loaded into the output register and shown on out_valid_o. An empty or
// fully cancelling crossing skips the CORDIC.
// Output channel: plane_angle_o, charge_total_o, empty_res_o on out_valid_o /
// out_ready_i, held in an output register. Hits of the next crossing are taken
// while a result waits; only the next result waits for the register to free.
// Reset clears the sums, the sequencer and the output valid.
module event_plane_angle_unit #(
  parameter int unsigned CHARGE_BITS  = 12,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [epa_pkg::CH_W-1:0]             channel_i,
  input  logic [epa_pkg::CHG_W-1:0]            charge_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [epa_pkg::ANG_W-1:0]     plane_angle_o,
  output logic [epa_pkg::CSUM_W-1:0]           charge_total_o,
  output logic                                 empty_res_o
);
  import epa_pkg::*;

  localparam int unsigned CB = (CHARGE_BITS < CHG_W) ? CHARGE_BITS : CHG_W;
  localparam logic [CHG_W-1:0] QMASK = CHG_W'((33'd1 << CB) - 33'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_FIN,
    S_ROT,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CHG_W-1:0]        q_q;
  coef_t                   coef_q;
  logic                    hit_q, last_q;
  logic signed [ANG_W-1:0] res_angle_q;
  logic                    out_valid_q;
  logic signed [ANG_W-1:0] plane_angle_q;
  logic [CSUM_W-1:0]       charge_total_q;
  logic                    empty_q;

  acc_ctrl_t               acc_ctrl;
  logic signed [Q_W-1:0]   qx, qy;
  logic [CSUM_W-1:0]       csum;
  logic                    run_cordic, cordic_start, cordic_done;
  logic signed [ANG_W-1:0] cordic_angle;
  logic                    accept, out_free, load_out;

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_ready_i;
  assign load_out     = (state_q == S_DONE) && out_free;
  assign run_cordic   = (csum != '0) && !((qx == '0) && (qy == '0));
  assign cordic_start = (state_q == S_FIN) && run_cordic;

  assign acc_ctrl = '{clear: load_out, add: (state_q == S_ACC) && hit_q};

  epa_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .q_i    (q_q),
    .coef_i (coef_q),
    .qx_o   (qx),
    .qy_o   (qy),
    .csum_o (csum)
  );

  epa_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (qx),
    .y_i     (qy),
    .done_o  (cordic_done),
    .angle_o (cordic_angle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state_q <= run_cordic ? S_ROT : S_DONE;
        end
        S_ROT: begin
          if (cordic_done) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q    <= charge_i & QMASK;
      coef_q <= seg_coef(channel_i);
      hit_q  <= (channel_i < NUM_CH);
      last_q <= last_i;
    end
    if (state_q == S_FIN && !run_cordic) res_angle_q <= '0;
    if (state_q == S_ROT && cordic_done) res_angle_q <= cordic_angle;
    if (load_out) begin
      plane_angle_q  <= res_angle_q;
      charge_total_q <= csum;
      empty_q        <= (csum == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plane_angle_o  = plane_angle_q;
  assign charge_total_o = charge_total_q;
  assign empty_res_o    = empty_q;

endmodule

// ===== hdl/epa_checker.sv =====
// Port-level assertions for the event plane angle unit and their bind.
module epa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [epa_pkg::CH_W-1:0]          channel_i,
  input logic [epa_pkg::CHG_W-1:0]         charge_i,
  input logic                              last_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [epa_pkg::ANG_W-1:0]  plane_angle_o,
  input logic [epa_pkg::CSUM_W-1:0]        charge_total_o,
  input logic                              empty_res_o
);
  import epa_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(plane_angle_o)
      && $stable(charge_total_o) && $stable(empty_res_o))
    else $error("result word changed while stalled");

  // a waiting hit word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(channel_i)
      && $stable(charge_i) && $stable(last_i))
    else $error("hit word changed while waiting");

  // every hit needs an accumulate cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("hit accepted on back-to-back cycles");

  // empty flag agrees with the total, and an empty crossing has angle zero
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_res_o == (charge_total_o == '0))
      && (!empty_res_o || plane_angle_o == '0))
    else $error("empty flag inconsistent with result");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (plane_angle_o >= -17'sd32768) && (plane_angle_o <= 17'sd32768))
    else $error("plane angle out of range");

endmodule

bind event_plane_angle_unit epa_checker u_epa_checker (.*);

// ===== tb/event_plane_angle_unit_tb.sv =====
// Self-checking testbench of the event plane angle unit: directed and random hit crossings checked per word.
module event_plane_angle_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epa_pkg::*;

  localparam int unsigned CHARGE_BITS  = 12;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int ROTATIONS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam longint Q_HI     = 64'sd34359738367;
  localparam longint Q_LO     = -64'sd34359738368;
  localparam int CHARGE_CAP   = 262143;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 12;
  localparam int RANDOM_HITS  = 200;

  localparam int RING8_SEG [8]  = '{5, 4, 3, 2, 6, 7, 0, 1};
  localparam int RING16_SEG [16] = '{11, 9, 7, 5, 13, 15, 1, 3, 10, 8, 6, 4, 12, 14, 0, 2};
  localparam int R8_COS [4]  = '{11585, -11585, -11585, 11585};
  localparam int R8_SIN [4]  = '{11585, 11585, -11585, -11585};
  localparam int R16_COS [8] = '{15137, 6270, -6270, -15137, -15137, -6270, 6270, 15137};
  localparam int R16_SIN [8] = '{6270, 15137, 15137, 6270, -6270, -15137, -15137, -6270};
  localparam int ATAN_TAB [24] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                                   3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [CHG_W-1:0] charge;
    logic             last;
  } hit_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic [CSUM_W-1:0]       total;
    logic                    empty;
  } plane_word_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [CH_W-1:0]          channel_i      = '0;
  logic [CHG_W-1:0]         charge_i       = '0;
  logic                     last_i         = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [ANG_W-1:0]  plane_angle_o;
  logic [CSUM_W-1:0]        charge_total_o;
  logic                     empty_res_o;

  hit_t        hit_q [$];
  plane_word_t plane_q [$];
  hit_t        cur_hit;
  plane_word_t got_word;

  longint qx_acc;
  longint qy_acc;
  int     charge_acc;

  int  hits_built   = 0;
  int  n_errors     = 0;
  int  results_seen = 0;
  int  cycle_cnt    = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  int  hold_cnt     = 0;
  bit  hold_done    = 1'b0;
  logic hold_off    = 1'b0;

  event_plane_angle_unit #(
    .CHARGE_BITS  (CHARGE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .charge_i       (charge_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .plane_angle_o  (plane_angle_o),
    .charge_total_o (charge_total_o),
    .empty_res_o    (empty_res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // cos(2phi), sin(2phi) of a channel in 0..47, Q1.14
  task automatic hit_coef(input logic [CH_W-1:0] ch, output int c, output int s);
    int m;
    if (ch < 6'd32) begin
      m = RING8_SEG[ch[2:0]] & 3;
      c = R8_COS[m];
      s = R8_SIN[m];
    end else begin
      m = RING16_SEG[ch[3:0]] & 7;
      c = R16_COS[m];
      s = R16_SIN[m];
    end
  endtask

  function automatic longint q_clamp(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Accumulate one accepted hit; on last, queue the expected plane word and clear.
  task automatic fold_hit(input hit_t h);
    int          c;
    int          s;
    int          i;
    longint      q;
    longint      x;
    longint      y;
    longint      t;
    longint      dx;
    longint      dy;
    longint      acc;
    plane_word_t w;
    q = longint'(h.charge) & ((64'sd1 <<< CHARGE_BITS) - 1);
    if (h.channel < NUM_CH) begin
      hit_coef(h.channel, c, s);
      qx_acc = q_clamp(qx_acc + q * longint'(c));
      qy_acc = q_clamp(qy_acc + q * longint'(s));
      charge_acc = charge_acc + int'(q);
      if (charge_acc > CHARGE_CAP) charge_acc = CHARGE_CAP;
    end
    if (h.last) begin
      acc = 0;
      if (charge_acc != 0 && !(qx_acc == 0 && qy_acc == 0)) begin
        x = qx_acc;
        y = qy_acc;
        // left half plane: quarter turn first
        if (x < 0) begin
          if (y >= 0) begin
            t = x; x = y; y = -t; acc = longint'(ANG_HALF_PI);
          end else begin
            t = x; x = -y; y = t; acc = -longint'(ANG_HALF_PI);
          end
        end
        for (i = 0; i < ROTATIONS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx; y = y - dy; acc = acc + ATAN_TAB[i];
          end else begin
            x = x - dx; y = y + dy; acc = acc - ATAN_TAB[i];
          end
        end
        if (acc > longint'(ANG_MAX)) acc = longint'(ANG_MAX);
        if (acc < longint'(ANG_MIN)) acc = longint'(ANG_MIN);
      end
      w.angle = acc[ANG_W-1:0];
      w.total = charge_acc[CSUM_W-1:0];
      w.empty = (charge_acc == 0);
      plane_q = {plane_q, w};
      qx_acc = 0;
      qy_acc = 0;
      charge_acc = 0;
    end
  endtask

  task automatic add_hit(input int ch, input int q, input bit last);
    hit_t h;
    h.channel = ch[CH_W-1:0];
    h.charge  = q[CHG_W-1:0];
    h.last    = last;
    hit_q = {hit_q, h};
    if (ch < 48) hits_built++;
  endtask

  function automatic int rand_charge();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  function automatic int rand_channel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(48, 63);
    return $urandom_range(0, 47);
  endfunction

  // mostly short gaps, a few long; no idling in the last quarter of each cycle_cnt period
  function automatic int idle_len();
    int r;
    if (cycle_cnt % 1024 >= 768) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input side driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) fold_hit(cur_hit);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 && !hold_off) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (hit_q.size() > 0) begin
          cur_hit = hit_q.pop_front();
          channel_i  <= cur_hit.channel;
          charge_i   <= cur_hit.charge;
          last_i     <= cur_hit.last;
          in_valid_i <= 1'b1;
          gap_left = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side monitor and ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (plane_q.size() == 0) begin
          $display("%0t unexpected plane word: angle %0d total %0d empty %0d",
                   $time, plane_angle_o, charge_total_o, empty_res_o);
          n_errors++;
        end else begin
          got_word = plane_q.pop_front();
          if (plane_angle_o !== got_word.angle) begin
            $display("%0t plane_angle expected %0d actual %0d",
                     $time, got_word.angle, plane_angle_o);
            n_errors++;
          end
          if (charge_total_o !== got_word.total) begin
            $display("%0t charge_total expected %0d actual %0d",
                     $time, got_word.total, charge_total_o);
            n_errors++;
          end
          if (empty_res_o !== got_word.empty) begin
            $display("%0t empty_res expected %0d actual %0d",
                     $time, got_word.empty, empty_res_o);
            n_errors++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // one long receiver hold-off so the unit backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      if (hold_cnt < HOLD_CYCLES) begin
        hold_off <= 1'b1;
        hold_cnt++;
      end else begin
        hold_off <= 1'b0;
        hold_done = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int kind;
    int len;
    int ch;
    int q;
    int a;
    int b;
    int ca;
    int sa;
    int cb;
    int sb;
    int keep;
    bit sat_done;
    sat_done   = 1'b0;
    qx_acc     = 0;
    qy_acc     = 0;
    charge_acc = 0;

    // directed crossings
    add_hit(0, 0, 1);                          // zero charge
    add_hit(63, 4095, 1);                      // only an ignored channel
    add_hit(1, 1000, 0); add_hit(3, 1000, 1);  // vectors cancel
    add_hit(0, 4095, 1);
    add_hit(2, 1, 1);
    add_hit(32, 4095, 1);
    add_hit(47, 2048, 1);
    add_hit(32, 100, 0); add_hit(43, 100, 1);  // x < 0, y = 0: top clamp
    add_hit(32, 100, 0); add_hit(43, 101, 1);  // x < 0, y just below 0
    add_hit(5, 300, 0); add_hit(50, 4095, 1);  // last carried by an ignored hit
    add_hit(48, 2730, 0); add_hit(21, 1365, 0); add_hit(42, 4095, 1);
    add_hit(6, 4095, 0); add_hit(7, 4095, 0); add_hit(4, 4095, 0); add_hit(5, 4095, 1);
    // charge total runs into its ceiling
    repeat (65) add_hit(9, 4095, 0);
    add_hit(9, 4095, 1);
    hits_built = 0;

    while (hits_built < RANDOM_HITS) begin
      kind = $urandom_range(0, 99);
      if (!sat_done && hits_built > 100) begin
        // Q sum saturation at negative x, then backing off; not counted in the budget
        keep = hits_built;
        repeat (560) add_hit(43, 4095, 0);
        repeat (4) add_hit(41, 4095, 0);
        add_hit(41, 4095, 1);
        hits_built = keep;
        sat_done = 1'b1;
      end else if (kind < 8) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 1)) add_hit($urandom_range(0, 47), 0, k == len - 1);
          else add_hit($urandom_range(48, 63), $urandom_range(0, 4095), k == len - 1);
        end
      end else if (kind < 15) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          a = $urandom_range(0, 47);
          hit_coef(a[CH_W-1:0], ca, sa);
          b = $urandom_range(0, 47);
          hit_coef(b[CH_W-1:0], cb, sb);
          while (cb != -ca || sb != -sa) begin
            b = (b + 1) % 48;
            hit_coef(b[CH_W-1:0], cb, sb);
          end
          q = $urandom_range(1, 4095);
          add_hit(a, q, 0);
          add_hit(b, q, k == len - 1);
        end
      end else if (kind < 20) begin
        len = $urandom_range(66, 80);
        for (int k = 0; k < len; k++)
          add_hit($urandom_range(0, 47), $urandom_range(3000, 4095), k == len - 1);
      end else begin
        len = (kind < 30) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          ch = rand_channel();
          add_hit(ch, rand_charge(), k == len - 1);
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (hit_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (plane_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
